// File: hdl/sps_pkg.sv
// Shared types, step codes and field-width table for the SPS header parser.
package sps_pkg;

    localparam int GOLOMB_MAX_BITS_DEF = 32;
    localparam logic [31:0] DEF_NUM = 32'd90000;
    localparam logic [31:0] DEF_DEN = 32'd3003;
    localparam logic [7:0] EPB_CODE = 8'h03;

    typedef enum logic [0:0] {
        REG_TIME_NUM = 1'b0,
        REG_TIME_DEN = 1'b1
    } cfg_idx_t;

    typedef enum logic [5:0] {
        P_PROFILE, P_CONSTR, P_LEVEL, P_SPSID, P_CHROMA, P_RESID, P_DEPTHL,
        P_DEPTHC, P_BYPASS, P_MATRIX, P_LISTFLAG, P_DELTA, P_LOG2FN, P_POCTYPE,
        P_POCLSB, P_DZERO, P_NONREF, P_TOPBOT, P_CYCLE, P_REFOFF, P_NUMREF,
        P_GAPS, P_WIDTH, P_HEIGHT, P_FRAMEONLY, P_MBAFF, P_DIRECT, P_CROP,
        P_CROPVAL, P_VUI, P_ARFLAG, P_ARIDC, P_SAR, P_OVERSCAN, P_OVEROK,
        P_VIDSIG, P_VFMT, P_FULL, P_COLDESC, P_COLVALS, P_LOCFLAG, P_LOCVAL,
        P_TIMING, P_UNITS, P_SCALE, P_FIXED, P_DONE
    } step_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ZERO = 2'd1,
        ST_SHORT = 2'd2,
        ST_OVFL = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [31:0] time_num;
        logic [32:0] time_den;
        logic [1:0]  status;
    } out_beat_t;

    // Byte queued for the bit engine; flags mark kept, last and first-of-set.
    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       last;
        logic       first;
    } cmd_t;

    // Width of a fixed field, zero for an Exp-Golomb code.
    function automatic logic [5:0] step_bits(input step_t s);
        logic [5:0] w;
        w = 6'd0;
        case (s)
            P_PROFILE, P_CONSTR, P_LEVEL, P_ARIDC: w = 6'd8;
            P_RESID, P_BYPASS, P_MATRIX, P_LISTFLAG, P_DZERO, P_GAPS,
            P_FRAMEONLY, P_MBAFF, P_DIRECT, P_CROP, P_VUI, P_ARFLAG,
            P_OVERSCAN, P_OVEROK, P_VIDSIG, P_FULL, P_COLDESC, P_LOCFLAG,
            P_TIMING, P_FIXED: w = 6'd1;
            P_VFMT: w = 6'd3;
            P_COLVALS: w = 6'd24;
            P_SAR, P_UNITS, P_SCALE: w = 6'd32;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

endpackage

// File: hdl/sps_front.sv
// Front end: accepts bytes, marks emulation-prevention bytes to drop, queues commands.
module sps_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sps_pkg::in_beat_t din,
    output logic             cmd_valid,
    output sps_pkg::cmd_t    cmd,
    input  logic             cmd_take
);
    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    sps_pkg::cmd_t     q_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic [1:0]        zrun_reg;
    logic              first_reg;
    logic              acc;
    logic              drop;
    sps_pkg::cmd_t     c;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign acc = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = q_reg[rp_reg];

    // Classify the incoming byte
    always_comb
    begin
        drop = (zrun_reg == 2'd2) && (din.data_byte == sps_pkg::EPB_CODE);
        c.data = din.data_byte;
        c.keep = !drop;
        c.last = din.last_byte;
        c.first = first_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    // Advance pointers and zero-run tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            zrun_reg <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (acc)
            begin
                wp_reg <= wp_reg + 1'b1;
                first_reg <= din.last_byte;
                if (din.last_byte)
                    zrun_reg <= 2'd0;
                else if (drop || din.data_byte != 8'd0)
                    zrun_reg <= 2'd0;
                else if (zrun_reg != 2'd2)
                    zrun_reg <= zrun_reg + 2'd1;
            end
            if (cmd_take)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(acc) - (AW+1)'(cmd_take);
        end
    end
endmodule

// File: hdl/sps_back.sv
// Back end: bit-serial field reader, syntax walker and result register.
module sps_back #(
    parameter int GOLOMB_MAX_BITS = sps_pkg::GOLOMB_MAX_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sps_pkg::cmd_t      cmd,
    output logic               cmd_take,
    input  logic [31:0]        def_num,
    input  logic [31:0]        def_den,
    output logic               empty,
    input  logic               pop,
    output sps_pkg::out_beat_t dout
);
    localparam logic [32:0] CAP = 33'((64'd1 << GOLOMB_MAX_BITS) - 64'd1);

    sps_pkg::step_t step_reg, step_next;
    logic [7:0]  buf_reg, buf_next;
    logic [3:0]  left_reg, left_next;
    logic        busy_reg, busy_next;
    logic        lastf_reg, lastf_next;
    logic [5:0]  gz_reg, gz_next;
    logic        suf_reg, suf_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  want_reg, want_next;
    logic [7:0]  loop_reg, loop_next;
    logic [6:0]  lidx_reg, lidx_next;
    logic [7:0]  lscale_reg, lscale_next;
    logic [7:0]  prof_reg, prof_next;
    logic        fo_reg, fo_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] h_reg, h_next;
    logic [31:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic        err_reg, err_next;
    logic        ov_reg, ov_next;
    sps_pkg::out_beat_t res_reg, res_next;

    logic        bit_in;
    logic        disp;
    logic [31:0] v;
    logic [32:0] sacc, gval;
    logic [32:0] sz;
    logic [32:0] mag;
    logic [7:0]  nscale;
    logic        report;

    assign empty = !ov_reg;
    assign dout = res_reg;
    // Hold off a set's last byte while an earlier result still waits
    assign cmd_take = cmd_valid && !busy_reg && !(ov_reg && !pop && cmd.last);

    // Step begin helper values
    function automatic logic [5:0] bw(input sps_pkg::step_t s);
        return sps_pkg::step_bits(s);
    endfunction

    always_comb
    begin
        step_next = step_reg; buf_next = buf_reg; left_next = left_reg;
        busy_next = busy_reg; lastf_next = lastf_reg; gz_next = gz_reg;
        suf_next = suf_reg; acc_next = acc_reg; want_next = want_reg;
        loop_next = loop_reg; lidx_next = lidx_reg; lscale_next = lscale_reg;
        prof_next = prof_reg; fo_next = fo_reg; w_next = w_reg; h_next = h_reg;
        num_next = num_reg; den_next = den_reg; err_next = err_reg;
        ov_next = ov_reg && !pop; res_next = res_reg;
        disp = 1'b0; v = '0; sacc = '0; gval = '0; sz = '0; mag = '0;
        nscale = '0; report = 1'b0;
        bit_in = buf_reg[7];

        // Load a byte from the queue
        if (cmd_take)
        begin
            lastf_next = cmd.last;
            if (cmd.first)
            begin
                num_next = def_num;
                den_next = {1'b0, def_den};
                if (step_reg == sps_pkg::P_PROFILE)
                    want_next = 6'd8;
            end
            if (cmd.keep)
            begin
                buf_next = cmd.data;
                left_next = 4'd8;
                busy_next = 1'b1;
            end
            else
            begin
                report = cmd.last;
            end
        end
        else if (busy_reg)
        begin
            // Consume one bit
            buf_next = {buf_reg[6:0], 1'b0};
            left_next = left_reg - 4'd1;
            if (left_reg == 4'd1)
            begin
                busy_next = 1'b0;
                report = lastf_reg;
            end
            if (step_reg != sps_pkg::P_DONE)
            begin
                if (bw(step_reg) != 6'd0)
                begin
                    acc_next = {acc_reg[30:0], bit_in};
                    want_next = want_reg - 6'd1;
                    if (want_reg == 6'd1)
                    begin
                        disp = 1'b1;
                        v = acc_next;
                    end
                end
                else if (!suf_reg)
                begin
                    if (!bit_in)
                    begin
                        if (gz_reg != 6'd63)
                            gz_next = gz_reg + 6'd1;
                    end
                    else if (gz_reg == 6'd0)
                    begin
                        disp = 1'b1;
                        v = '0;
                    end
                    else
                    begin
                        suf_next = 1'b1;
                        want_next = gz_reg;
                        acc_next = '0;
                    end
                end
                else
                begin
                    sacc = {acc_reg, bit_in};
                    if (sacc > CAP)
                        sacc = CAP;
                    acc_next = sacc[31:0];
                    want_next = want_reg - 6'd1;
                    if (want_reg == 6'd1)
                    begin
                        if (32'(gz_reg) >= 32'(GOLOMB_MAX_BITS))
                            gval = CAP;
                        else
                        begin
                            gval = ((33'd1 << gz_reg) - 33'd1) + {1'b0, sacc[31:0]};
                            if (gval > CAP)
                                gval = CAP;
                        end
                        disp = 1'b1;
                        v = gval[31:0];
                    end
                end
            end
        end

        // Walk the syntax on a completed field
        if (disp)
        begin
            gz_next = '0;
            suf_next = 1'b0;
            acc_next = '0;
            case (step_reg)
                sps_pkg::P_PROFILE: begin prof_next = v[7:0]; step_next = sps_pkg::P_CONSTR; end
                sps_pkg::P_CONSTR: step_next = sps_pkg::P_LEVEL;
                sps_pkg::P_LEVEL: step_next = sps_pkg::P_SPSID;
                sps_pkg::P_SPSID:
                    step_next = (prof_reg == 8'd100 || prof_reg == 8'd110 ||
                                 prof_reg == 8'd122 || prof_reg == 8'd144)
                                ? sps_pkg::P_CHROMA : sps_pkg::P_LOG2FN;
                sps_pkg::P_CHROMA:
                    step_next = (v == 32'd3) ? sps_pkg::P_RESID : sps_pkg::P_DEPTHL;
                sps_pkg::P_RESID: step_next = sps_pkg::P_DEPTHL;
                sps_pkg::P_DEPTHL: step_next = sps_pkg::P_DEPTHC;
                sps_pkg::P_DEPTHC: step_next = sps_pkg::P_BYPASS;
                sps_pkg::P_BYPASS: step_next = sps_pkg::P_MATRIX;
                sps_pkg::P_MATRIX:
                begin
                    loop_next = '0;
                    step_next = v[0] ? sps_pkg::P_LISTFLAG : sps_pkg::P_LOG2FN;
                end
                sps_pkg::P_LISTFLAG:
                begin
                    if (v[0])
                    begin
                        lidx_next = '0;
                        lscale_next = 8'd8;
                        step_next = sps_pkg::P_DELTA;
                    end
                    else
                    begin
                        loop_next = loop_reg + 8'd1;
                        step_next = (loop_next >= 8'd8) ? sps_pkg::P_LOG2FN
                                                        : sps_pkg::P_LISTFLAG;
                    end
                end
                sps_pkg::P_DELTA:
                begin
                    mag = {2'b0, v[31:1]} + {32'd0, v[0]};
                    nscale = v[0] ? lscale_reg + mag[7:0] : lscale_reg - mag[7:0];
                    if (nscale != 8'd0)
                        lscale_next = nscale;
                    lidx_next = lidx_reg + 7'd1;
                    if (nscale == 8'd0 ||
                        lidx_next >= ((loop_reg < 8'd6) ? 7'd16 : 7'd64))
                    begin
                        loop_next = loop_reg + 8'd1;
                        step_next = (loop_next >= 8'd8) ? sps_pkg::P_LOG2FN
                                                        : sps_pkg::P_LISTFLAG;
                    end
                    else
                        step_next = sps_pkg::P_DELTA;
                end
                sps_pkg::P_LOG2FN: step_next = sps_pkg::P_POCTYPE;
                sps_pkg::P_POCTYPE:
                    step_next = (v == 32'd0) ? sps_pkg::P_POCLSB :
                                (v == 32'd1) ? sps_pkg::P_DZERO : sps_pkg::P_NUMREF;
                sps_pkg::P_POCLSB: step_next = sps_pkg::P_NUMREF;
                sps_pkg::P_DZERO: step_next = sps_pkg::P_NONREF;
                sps_pkg::P_NONREF: step_next = sps_pkg::P_TOPBOT;
                sps_pkg::P_TOPBOT: step_next = sps_pkg::P_CYCLE;
                sps_pkg::P_CYCLE:
                begin
                    loop_next = (v > 32'd255) ? 8'd255 : v[7:0];
                    step_next = (loop_next != 8'd0) ? sps_pkg::P_REFOFF
                                                    : sps_pkg::P_NUMREF;
                end
                sps_pkg::P_REFOFF:
                begin
                    loop_next = loop_reg - 8'd1;
                    step_next = (loop_next != 8'd0) ? sps_pkg::P_REFOFF
                                                    : sps_pkg::P_NUMREF;
                end
                sps_pkg::P_NUMREF: step_next = sps_pkg::P_GAPS;
                sps_pkg::P_GAPS: step_next = sps_pkg::P_WIDTH;
                sps_pkg::P_WIDTH:
                begin
                    sz = ({1'b0, v} + 33'd1);
                    if (sz > 33'd4095) begin w_next = 16'hFFFF; err_next = 1'b1; end
                    else w_next = {sz[11:0], 4'd0};
                    step_next = sps_pkg::P_HEIGHT;
                end
                sps_pkg::P_HEIGHT:
                begin
                    sz = ({1'b0, v} + 33'd1);
                    if (sz > 33'd4095) begin h_next = 16'hFFFF; err_next = 1'b1; end
                    else h_next = {sz[11:0], 4'd0};
                    step_next = sps_pkg::P_FRAMEONLY;
                end
                sps_pkg::P_FRAMEONLY:
                begin
                    fo_next = v[0];
                    if (!v[0])
                    begin
                        if (h_reg[15]) begin h_next = 16'hFFFF; err_next = 1'b1; end
                        else h_next = {h_reg[14:0], 1'b0};
                        step_next = sps_pkg::P_MBAFF;
                    end
                    else
                        step_next = sps_pkg::P_DIRECT;
                end
                sps_pkg::P_MBAFF: step_next = sps_pkg::P_DIRECT;
                sps_pkg::P_DIRECT: step_next = sps_pkg::P_CROP;
                sps_pkg::P_CROP:
                begin
                    loop_next = 8'd4;
                    step_next = v[0] ? sps_pkg::P_CROPVAL : sps_pkg::P_VUI;
                end
                sps_pkg::P_CROPVAL:
                begin
                    loop_next = loop_reg - 8'd1;
                    step_next = (loop_next != 8'd0) ? sps_pkg::P_CROPVAL
                                                    : sps_pkg::P_VUI;
                end
                sps_pkg::P_VUI: step_next = v[0] ? sps_pkg::P_ARFLAG : sps_pkg::P_DONE;
                sps_pkg::P_ARFLAG:
                    step_next = v[0] ? sps_pkg::P_ARIDC : sps_pkg::P_OVERSCAN;
                sps_pkg::P_ARIDC:
                    step_next = (v == 32'd255) ? sps_pkg::P_SAR : sps_pkg::P_OVERSCAN;
                sps_pkg::P_SAR: step_next = sps_pkg::P_OVERSCAN;
                sps_pkg::P_OVERSCAN:
                    step_next = v[0] ? sps_pkg::P_OVEROK : sps_pkg::P_VIDSIG;
                sps_pkg::P_OVEROK: step_next = sps_pkg::P_VIDSIG;
                sps_pkg::P_VIDSIG:
                    step_next = v[0] ? sps_pkg::P_VFMT : sps_pkg::P_LOCFLAG;
                sps_pkg::P_VFMT: step_next = sps_pkg::P_FULL;
                sps_pkg::P_FULL: step_next = sps_pkg::P_COLDESC;
                sps_pkg::P_COLDESC:
                    step_next = v[0] ? sps_pkg::P_COLVALS : sps_pkg::P_LOCFLAG;
                sps_pkg::P_COLVALS: step_next = sps_pkg::P_LOCFLAG;
                sps_pkg::P_LOCFLAG:
                begin
                    loop_next = 8'd2;
                    step_next = v[0] ? sps_pkg::P_LOCVAL : sps_pkg::P_TIMING;
                end
                sps_pkg::P_LOCVAL:
                begin
                    loop_next = loop_reg - 8'd1;
                    step_next = (loop_next != 8'd0) ? sps_pkg::P_LOCVAL
                                                    : sps_pkg::P_TIMING;
                end
                sps_pkg::P_TIMING:
                    step_next = v[0] ? sps_pkg::P_UNITS : sps_pkg::P_DONE;
                sps_pkg::P_UNITS: begin den_next = {1'b0, v}; step_next = sps_pkg::P_SCALE; end
                sps_pkg::P_SCALE: begin num_next = v; step_next = sps_pkg::P_FIXED; end
                sps_pkg::P_FIXED:
                begin
                    if (v[0])
                        den_next = fo_reg ? {den_reg[31:0], 1'b0} : {1'b0, den_reg[31:0]};
                    else
                    begin
                        num_next = def_num;
                        den_next = {1'b0, def_den};
                    end
                    step_next = sps_pkg::P_DONE;
                end
                default: step_next = sps_pkg::P_DONE;
            endcase
            want_next = bw(step_next);
        end

        // Drop a result into the output register and restart
        if (report)
        begin
            res_next.frame_width = w_next;
            res_next.frame_height = h_next;
            res_next.time_num = num_next;
            res_next.time_den = den_next;
            if (step_next != sps_pkg::P_DONE)
                res_next.status = sps_pkg::ST_SHORT;
            else if (err_next)
                res_next.status = sps_pkg::ST_OVFL;
            else if (w_next == '0 || h_next == '0 || num_next == '0 || den_next == '0)
                res_next.status = sps_pkg::ST_ZERO;
            else
                res_next.status = sps_pkg::ST_OK;
            ov_next = 1'b1;
            step_next = sps_pkg::P_PROFILE; want_next = '0; acc_next = '0;
            gz_next = '0; suf_next = 1'b0; loop_next = '0; lidx_next = '0;
            lscale_next = 8'd8; prof_next = '0; fo_next = 1'b0; w_next = '0;
            h_next = '0; num_next = def_num; den_next = {1'b0, def_den};
            err_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= sps_pkg::P_PROFILE; left_reg <= '0; busy_reg <= 1'b0;
            lastf_reg <= 1'b0; gz_reg <= '0; suf_reg <= 1'b0; acc_reg <= '0;
            want_reg <= '0; loop_reg <= '0; lidx_reg <= '0; lscale_reg <= 8'd8;
            prof_reg <= '0; fo_reg <= 1'b0; w_reg <= '0; h_reg <= '0;
            num_reg <= sps_pkg::DEF_NUM; den_reg <= {1'b0, sps_pkg::DEF_DEN};
            err_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next; left_reg <= left_next; busy_reg <= busy_next;
            lastf_reg <= lastf_next; gz_reg <= gz_next; suf_reg <= suf_next;
            acc_reg <= acc_next; want_reg <= want_next; loop_reg <= loop_next;
            lidx_reg <= lidx_next; lscale_reg <= lscale_next; prof_reg <= prof_next;
            fo_reg <= fo_next; w_reg <= w_next; h_reg <= h_next;
            num_reg <= num_next; den_reg <= den_next; err_reg <= err_next;
            ov_reg <= ov_next;
        end
    end
endmodule

// File: hdl/h264_sps_header_parser.sv
// Top level of the SPS header parser: configuration registers, front and back.
//  channel | direction | handshake         | payload
//  in      | input     | push / full       | in_beat_t  (data_byte, last_byte)
//  out     | output    | empty / pop       | out_beat_t (size, time base, status)
//  cfg     | input     | cfg_we, cfg_index | cfg_data, 32 bit
// The bit-serial back end loads each kept byte and then shifts out its eight bits
// one at a time; a dropped emulation-prevention byte is only loaded. A four-beat
// queue sits between front and back. Reset clears both ends; defaults return to
// 90000 / 3003. A waiting result that is not being popped holds the next set's last
// byte at the back end; the queue then fills and raises full.
module h264_sps_header_parser #(
    parameter int GOLOMB_MAX_BITS = sps_pkg::GOLOMB_MAX_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  sps_pkg::in_beat_t  din,
    output logic               empty,
    input  logic               pop,
    output sps_pkg::out_beat_t dout,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    logic          cmd_valid, cmd_take;
    sps_pkg::cmd_t cmd;
    logic [31:0]   num_reg, den_reg;

    // Hold the default time base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= sps_pkg::DEF_NUM;
            den_reg <= sps_pkg::DEF_DEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sps_pkg::REG_TIME_NUM: num_reg <= cfg_data;
                sps_pkg::REG_TIME_DEN: den_reg <= cfg_data;
                default: num_reg <= num_reg;
            endcase
        end
    end

    sps_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .din(din),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    sps_back #(.GOLOMB_MAX_BITS(GOLOMB_MAX_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .def_num(num_reg), .def_den(den_reg),
        .empty(empty), .pop(pop), .dout(dout)
    );
endmodule

// File: hdl/sps_checker.sv
// Port-level checker for the SPS header parser, bound to the top level.
module sps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input sps_pkg::out_beat_t dout
);
    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(dout))
        else $error("result changed while waiting");

    // An ok status always carries a nonzero size
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && dout.status == sps_pkg::ST_OK |->
        dout.frame_width != '0 && dout.frame_height != '0)
        else $error("ok status with zero size");

    // Overflow status carries a saturated dimension
    a_ovfl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && dout.status == sps_pkg::ST_OVFL |->
        dout.frame_width == 16'hFFFF || dout.frame_height == 16'hFFFF)
        else $error("overflow status without saturated size");

    // Width is always a multiple of sixteen or saturated
    a_w16: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> dout.frame_width[3:0] == 4'd0 || dout.frame_width == 16'hFFFF)
        else $error("width not macroblock aligned");
endmodule

bind h264_sps_header_parser sps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .dout(dout)
);

// File: bench/tb_h264_sps_header_parser.sv
// Self-checking bench for the SPS header parser: bitstream builder, report predictor, drivers.
`timescale 1ns / 1ps

module tb_h264_sps_header_parser;
    import sps_pkg::*;

    // Predicts the report of each parameter set from the byte stream.
    class sps_report_tracker;
        step_t       step;
        int          zero_run, gz, want;
        bit          suffix, fonly, ovfl;
        logic [31:0] acc, nreg, dnum, dden;
        logic [63:0] dreg;
        logic [7:0]  loop_cnt, last_sc, next_sc, profile;
        int          lidx;
        logic [15:0] wreg, hreg;
        out_beat_t   reports_due[$];
        int          fails, reports_seen;

        function new();
            dnum = DEF_NUM;
            dden = DEF_DEN;
            fails = 0;
            reports_seen = 0;
            restart();
        endfunction

        function void set_default(cfg_idx_t idx, logic [31:0] d);
            if (idx == REG_TIME_NUM) dnum = d;
            else dden = d;
        endfunction

        function int field_width(step_t s);
            case (s)
                P_PROFILE, P_CONSTR, P_LEVEL, P_ARIDC: return 8;
                P_RESID, P_BYPASS, P_MATRIX, P_LISTFLAG, P_DZERO, P_GAPS,
                P_FRAMEONLY, P_MBAFF, P_DIRECT, P_CROP, P_VUI, P_ARFLAG,
                P_OVERSCAN, P_OVEROK, P_VIDSIG, P_FULL, P_COLDESC, P_LOCFLAG,
                P_TIMING, P_FIXED: return 1;
                P_VFMT: return 3;
                P_COLVALS: return 24;
                P_SAR, P_UNITS, P_SCALE: return 32;
                default: return 0;
            endcase
        endfunction

        function void go(step_t s);
            step = s;
            want = field_width(s);
            acc = 0;
            gz = 0;
            suffix = 0;
        endfunction

        function void restart();
            step = P_PROFILE;
            want = 0;
            acc = 0;
            gz = 0;
            suffix = 0;
            zero_run = 0;
            loop_cnt = 0;
            lidx = 0;
            last_sc = 8;
            next_sc = 8;
            profile = 0;
            fonly = 0;
            wreg = 0;
            hreg = 0;
            nreg = dnum;
            dreg = {32'd0, dden};
            ovfl = 0;
        endfunction

        function logic [15:0] clip_size(logic [63:0] v);
            if (v > 64'd65535)
            begin
                ovfl = 1;
                return 16'hFFFF;
            end
            return v[15:0];
        endfunction

        function void list_done();
            loop_cnt++;
            go(loop_cnt >= 8 ? P_LOG2FN : P_LISTFLAG);
        endfunction

        function void dispatch(logic [31:0] v);
            logic [63:0] mag;
            logic [7:0]  d;
            case (step)
                P_PROFILE: begin profile = v[7:0]; go(P_CONSTR); end
                P_CONSTR: go(P_LEVEL);
                P_LEVEL: go(P_SPSID);
                P_SPSID:
                    if (profile == 100 || profile == 110 || profile == 122 || profile == 144)
                        go(P_CHROMA);
                    else
                        go(P_LOG2FN);
                P_CHROMA: go(v == 3 ? P_RESID : P_DEPTHL);
                P_RESID: go(P_DEPTHL);
                P_DEPTHL: go(P_DEPTHC);
                P_DEPTHC: go(P_BYPASS);
                P_BYPASS: go(P_MATRIX);
                P_MATRIX: begin loop_cnt = 0; go(v != 0 ? P_LISTFLAG : P_LOG2FN); end
                P_LISTFLAG:
                    if (v != 0)
                    begin
                        lidx = 0;
                        last_sc = 8;
                        next_sc = 8;
                        go(P_DELTA);
                    end
                    else
                        list_done();
                P_DELTA:
                begin
                    mag = {33'd0, v[31:1]} + {63'd0, v[0]};
                    d = v[0] ? mag[7:0] : 8'(8'd0 - mag[7:0]);
                    next_sc = 8'(last_sc + d);
                    if (next_sc != 0) last_sc = next_sc;
                    lidx++;
                    if (next_sc == 0 || lidx >= (loop_cnt < 6 ? 16 : 64)) list_done();
                    else go(P_DELTA);
                end
                P_LOG2FN: go(P_POCTYPE);
                P_POCTYPE: go(v == 0 ? P_POCLSB : (v == 1 ? P_DZERO : P_NUMREF));
                P_POCLSB: go(P_NUMREF);
                P_DZERO: go(P_NONREF);
                P_NONREF: go(P_TOPBOT);
                P_TOPBOT: go(P_CYCLE);
                P_CYCLE:
                begin
                    loop_cnt = (v > 255) ? 8'd255 : v[7:0];
                    go(loop_cnt != 0 ? P_REFOFF : P_NUMREF);
                end
                P_REFOFF: begin loop_cnt--; go(loop_cnt != 0 ? P_REFOFF : P_NUMREF); end
                P_NUMREF: go(P_GAPS);
                P_GAPS: go(P_WIDTH);
                P_WIDTH: begin wreg = clip_size(({32'd0, v} + 1) * 16); go(P_HEIGHT); end
                P_HEIGHT: begin hreg = clip_size(({32'd0, v} + 1) * 16); go(P_FRAMEONLY); end
                P_FRAMEONLY:
                begin
                    fonly = v[0];
                    if (!fonly)
                    begin
                        hreg = clip_size({48'd0, hreg} * 2);
                        go(P_MBAFF);
                    end
                    else
                        go(P_DIRECT);
                end
                P_MBAFF: go(P_DIRECT);
                P_DIRECT: go(P_CROP);
                P_CROP: begin loop_cnt = 4; go(v != 0 ? P_CROPVAL : P_VUI); end
                P_CROPVAL: begin loop_cnt--; go(loop_cnt != 0 ? P_CROPVAL : P_VUI); end
                P_VUI: go(v != 0 ? P_ARFLAG : P_DONE);
                P_ARFLAG: go(v != 0 ? P_ARIDC : P_OVERSCAN);
                P_ARIDC: go(v == 255 ? P_SAR : P_OVERSCAN);
                P_SAR: go(P_OVERSCAN);
                P_OVERSCAN: go(v != 0 ? P_OVEROK : P_VIDSIG);
                P_OVEROK: go(P_VIDSIG);
                P_VIDSIG: go(v != 0 ? P_VFMT : P_LOCFLAG);
                P_VFMT: go(P_FULL);
                P_FULL: go(P_COLDESC);
                P_COLDESC: go(v != 0 ? P_COLVALS : P_LOCFLAG);
                P_COLVALS: go(P_LOCFLAG);
                P_LOCFLAG: begin loop_cnt = 2; go(v != 0 ? P_LOCVAL : P_TIMING); end
                P_LOCVAL: begin loop_cnt--; go(loop_cnt != 0 ? P_LOCVAL : P_TIMING); end
                P_TIMING: go(v != 0 ? P_UNITS : P_DONE);
                P_UNITS: begin dreg = {32'd0, v}; go(P_SCALE); end
                P_SCALE: begin nreg = v; go(P_FIXED); end
                P_FIXED:
                begin
                    if (v != 0)
                        dreg = {32'd0, dreg[31:0]} * (fonly ? 64'd2 : 64'd1);
                    else
                    begin
                        nreg = dnum;
                        dreg = {32'd0, dden};
                    end
                    go(P_DONE);
                end
                default: step = P_DONE;
            endcase
        endfunction

        function void take_bit(bit b);
            logic [63:0] a;
            if (step >= P_DONE) return;
            if (field_width(step) != 0)
            begin
                acc = {acc[30:0], b};
                want--;
                if (want == 0) dispatch(acc);
                return;
            end
            // Exp-Golomb prefix: count zeros up to the marker bit
            if (!suffix)
            begin
                if (!b)
                begin
                    if (gz < 63) gz++;
                end
                else if (gz == 0)
                    dispatch(0);
                else
                begin
                    suffix = 1;
                    want = gz;
                    acc = 0;
                end
                return;
            end
            a = {32'd0, acc} * 2 + b;
            acc = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            want--;
            if (want == 0)
            begin
                if (gz >= 32) a = 64'hFFFF_FFFF;
                else
                begin
                    a = (64'd1 << gz) - 1 + {32'd0, acc};
                    if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
                end
                dispatch(a[31:0]);
            end
        endfunction

        function void note_byte(in_beat_t b);
            out_beat_t r;
            if (step == P_PROFILE && want == 0)
            begin
                nreg = dnum;
                dreg = {32'd0, dden};
                want = 8;
            end
            // drop emulation-prevention bytes
            if (zero_run >= 2 && b.data_byte == EPB_CODE)
                zero_run = 0;
            else
            begin
                zero_run = (b.data_byte == 0) ? (zero_run < 2 ? zero_run + 1 : 2) : 0;
                for (int i = 7; i >= 0; i--) take_bit(b.data_byte[i]);
            end
            if (!b.last_byte) return;
            r.frame_width = wreg;
            r.frame_height = hreg;
            r.time_num = nreg;
            r.time_den = dreg[32:0];
            if (step != P_DONE) r.status = ST_SHORT;
            else if (ovfl) r.status = ST_OVFL;
            else if (wreg == 0 || hreg == 0 || nreg == 0 || dreg[32:0] == 0) r.status = ST_ZERO;
            else r.status = ST_OK;
            reports_due.push_back(r);
            restart();
        endfunction

        function void check_report(out_beat_t got);
            out_beat_t e;
            reports_seen++;
            if (reports_due.size() == 0)
            begin
                $error("report with none expected: %p", got);
                fails++;
                return;
            end
            e = reports_due.pop_front();
            if (got.frame_width !== e.frame_width)
            begin
                $error("frame_width exp %0d got %0d", e.frame_width, got.frame_width);
                fails++;
            end
            if (got.frame_height !== e.frame_height)
            begin
                $error("frame_height exp %0d got %0d", e.frame_height, got.frame_height);
                fails++;
            end
            if (got.time_num !== e.time_num)
            begin
                $error("time_num exp %0d got %0d", e.time_num, got.time_num);
                fails++;
            end
            if (got.time_den !== e.time_den)
            begin
                $error("time_den exp %0d got %0d", e.time_den, got.time_den);
                fails++;
            end
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic        clk, rst_n, push, full, empty, pop, cfg_we, cfg_index;
    logic [31:0] cfg_data;
    in_beat_t    din;
    out_beat_t   dout;

    sps_report_tracker tracker;
    bit                bits_q[$];
    logic [7:0]        set_q[$];
    int                bytes_sent, sets_sent, full_stalls;

    h264_sps_header_parser u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .din(din),
        .empty(empty), .pop(pop), .dout(dout),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("h264_sps_header_parser regression: fail");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bitstream building
    function void put(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
    endfunction

    function void put_ue(logic [63:0] v);
        logic [63:0] c, t;
        int len;
        c = v + 1;
        t = c;
        len = 0;
        while (t != 0)
        begin
            len++;
            t = t >> 1;
        end
        repeat (len - 1) bits_q.push_back(1'b0);
        put(c, len);
    endfunction

    function void put_se(int s);
        put_ue(s > 0 ? 2 * s - 1 : -2 * s);
    endfunction

    function logic [63:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return $urandom_range(4095, 5000);
        if (r < 9) return 2047;
        if (r < 12) return 0;
        return $urandom_range(0, 119);
    endfunction

    // Append one well-formed parameter set to the bit queue.
    function void build_sps();
        logic [7:0] prof, ls, ns;
        int pt, n, d, r;
        bit fo;
        r = $urandom_range(0, 5);
        prof = (r == 0) ? 8'd66 : (r == 1) ? 8'd100 : (r == 2) ? 8'd110 :
               (r == 3) ? 8'd122 : (r == 4) ? 8'd144 : 8'($urandom);
        put(prof, 8);
        put($urandom, 8);
        put($urandom, 8);
        // occasionally an overlong Exp-Golomb code that saturates
        if ($urandom_range(0, 19) == 0)
        begin
            repeat (40) bits_q.push_back(1'b0);
            bits_q.push_back(1'b1);
            put({$urandom, $urandom}, 40);
        end
        else
            put_ue($urandom_range(0, 31));
        if (prof == 100 || prof == 110 || prof == 122 || prof == 144)
        begin
            n = $urandom_range(0, 3);
            put_ue(n);
            if (n == 3) put($urandom, 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put($urandom, 1);
            if ($urandom_range(0, 1))
            begin
                put(1, 1);
                for (int i = 0; i < 8; i++)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        put(1, 1);
                        ls = 8;
                        for (int j = 0; j < (i < 6 ? 16 : 64); j++)
                        begin
                            d = ($urandom_range(0, 9) == 0) ? -int'(ls) : $urandom_range(0, 16) - 8;
                            if ($urandom_range(0, 49) == 0) d = $urandom_range(0, 255) - 128;
                            put_se(d);
                            ns = 8'(ls + d);
                            if (ns == 0) break;
                            ls = ns;
                        end
                    end
                    else
                        put(0, 1);
                end
            end
            else
                put(0, 1);
        end
        put_ue($urandom_range(0, 12));
        pt = $urandom_range(0, 2);
        put_ue(pt);
        if (pt == 0) put_ue($urandom_range(0, 12));
        if (pt == 1)
        begin
            put($urandom, 1);
            put_se($urandom_range(0, 40) - 20);
            put_se($urandom_range(0, 40) - 20);
            n = ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(0, 5);
            put_ue(n);
            repeat (n) put_se($urandom_range(0, 10) - 5);
        end
        put_ue($urandom_range(0, 16));
        put($urandom, 1);
        put_ue(pick_size());
        put_ue(pick_size());
        fo = $urandom;
        put(fo, 1);
        if (!fo) put($urandom, 1);
        put($urandom, 1);
        if ($urandom_range(0, 1))
        begin
            put(1, 1);
            repeat (4) put_ue($urandom_range(0, 20));
        end
        else
            put(0, 1);
        if ($urandom_range(0, 4) == 0)
        begin
            put(0, 1);
            return;
        end
        put(1, 1);
        if ($urandom_range(0, 1))
        begin
            put(1, 1);
            n = ($urandom_range(0, 1)) ? 255 : $urandom_range(0, 254);
            put(n, 8);
            if (n == 255) put($urandom, 32);
        end
        else
            put(0, 1);
        if ($urandom_range(0, 1)) begin put(1, 1); put($urandom, 1); end
        else put(0, 1);
        if ($urandom_range(0, 1))
        begin
            put(1, 1);
            put($urandom, 3);
            put($urandom, 1);
            if ($urandom_range(0, 1)) begin put(1, 1); put($urandom, 24); end
            else put(0, 1);
        end
        else
            put(0, 1);
        if ($urandom_range(0, 1))
        begin
            put(1, 1);
            put_ue($urandom_range(0, 5));
            put_ue($urandom_range(0, 5));
        end
        else
            put(0, 1);
        if ($urandom_range(0, 3) != 0)
        begin
            put(1, 1);
            r = $urandom_range(0, 9);
            put(r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF : $urandom, 32);
            r = $urandom_range(0, 9);
            put(r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF : $urandom, 32);
            put($urandom, 1);
        end
        else
            put(0, 1);
    endfunction

    // Close the bit queue with stop bit and padding, insert emulation prevention, append junk.
    function void pack_bytes(int junk);
        int z;
        logic [7:0] b;
        bits_q.push_back(1'b1);
        while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
        z = 0;
        while (bits_q.size() > 0)
        begin
            for (int i = 7; i >= 0; i--) b[i] = bits_q.pop_front();
            if (z >= 2 && b <= 3)
            begin
                set_q.push_back(EPB_CODE);
                z = 0;
            end
            set_q.push_back(b);
            z = (b == 0) ? z + 1 : 0;
        end
        repeat (junk) set_q.push_back($urandom);
    endfunction

    task automatic send_beat(in_beat_t b);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        din <= b;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // Send the queued set, optionally cut short.
    task automatic send_set(bit cut);
        int n;
        n = set_q.size();
        if (cut && n > 1) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) send_beat('{data_byte: set_q[i], last_byte: (i == n - 1)});
        set_q.delete();
        sets_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_default(idx, d);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (tracker.reports_due.size() > 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_set();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            // noise: random bytes, heavy on zeros
            repeat ($urandom_range(1, 30))
                set_q.push_back($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom));
            send_set(0);
        end
        else
        begin
            build_sps();
            pack_bytes($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            send_set(r < 30);
        end
    endtask

    // Receiver: random pops with one long hold-off to back up the input.
    initial
    begin
        int g;
        bit held;
        held = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && tracker.reports_seen == 10)
            begin
                held = 1;
                pop <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            g = pick_gap();
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            tracker.check_report(dout);
        end
    end

    initial
    begin
        logic [31:0] nums[4], dens[4];
        tracker = new();
        bytes_sent = 0;
        sets_sent = 0;
        full_stalls = 0;
        rst_n = 1'b0;
        push = 1'b0;
        din = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: minimal baseline set, lone last byte, zeros with a dropped 0x03
        put(66, 8); put(0, 8); put(30, 8); put_ue(0); put_ue(0); put_ue(0); put_ue(0);
        put_ue(1); put(0, 1); put_ue(19); put_ue(14); put(1, 1); put(0, 1); put(0, 1);
        put(0, 1);
        pack_bytes(0);
        send_set(0);
        send_beat('{data_byte: 8'hFF, last_byte: 1'b1});
        send_beat('{data_byte: 8'h00, last_byte: 1'b0});
        send_beat('{data_byte: 8'h00, last_byte: 1'b0});
        send_beat('{data_byte: 8'h03, last_byte: 1'b0});
        send_beat('{data_byte: 8'h80, last_byte: 1'b1});
        drain();

        nums[0] = 32'd0;          dens[0] = 32'd0;
        nums[1] = 32'hFFFF_FFFF;  dens[1] = 32'hFFFF_FFFF;
        nums[2] = $urandom;       dens[2] = $urandom;
        nums[3] = DEF_NUM;        dens[3] = DEF_DEN;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_TIME_NUM, nums[p]);
            write_reg(REG_TIME_DEN, dens[p]);
            while (bytes_sent < 40 + (p + 1) * 460) random_set();
            drain();
        end

        $display("sent %0d bytes in %0d sets over 4 time-base settings", bytes_sent, sets_sent);
        $display("checked %0d reports, input stalled %0d cycles", tracker.reports_seen,
                 full_stalls);
        if (tracker.fails == 0 && tracker.reports_due.size() == 0)
            $display("h264_sps_header_parser regression: pass");
        else
            $display("h264_sps_header_parser regression: fail");
        $finish;
    end

endmodule
